// File: rtl/stl_pkg.sv
`default_nettype none
package stl_pkg;

	localparam int CAPACITY     = 16;
	localparam int HANDLE_COUNT = 64;
	localparam int KEY_WIDTH    = 32;

	localparam int OP_W   = 2;
	localparam int HND_W  = 6;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int STAT_W = 2;

	localparam int IN_DATA_W  = ((OP_W + HND_W + KEY_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((CNT_W + STAT_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_SORTED = 2'd0;
	localparam logic [OP_W-1:0] OP_TAIL   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_LISTED = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd3;

	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/stl_ctrl.sv
`default_nettype none
module stl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output stl_pkg::dp_cmd_t     cmd
);
	import stl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_ready && in_valid;
	assign cmd.commit = (state_q == ST_EXEC) && slot_free;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/stl_datapath.sv
`default_nettype none
module stl_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stl_pkg::dp_cmd_t              cmd,
	input  wire logic [stl_pkg::OP_W-1:0]      opcode,
	input  wire logic [stl_pkg::HND_W-1:0]     handle,
	input  wire logic [stl_pkg::KEY_WIDTH-1:0] sort_key,
	output logic [stl_pkg::CNT_W-1:0]          remaining_count,
	output logic [stl_pkg::STAT_W-1:0]         status
);
	import stl_pkg::*;

	logic [OP_W-1:0]      op_s1;
	logic [HND_W-1:0]     hnd_s1;
	logic [KEY_WIDTH-1:0] key_s1;

	logic [KEY_WIDTH-1:0] slot_key_q [CAPACITY];
	logic [HND_W-1:0]     slot_hnd_q [CAPACITY];
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     res_count_q;
	logic [STAT_W-1:0]    res_status_q;

	logic [CAPACITY-1:0]  valid;
	logic [CAPACITY-1:0]  gt;
	logic [CAPACITY-1:0]  match;
	logic [CAPACITY-1:0]  after_ins;
	logic [CAPACITY-1:0]  after_rm;
	logic                 tail_mode;
	logic                 in_range;
	logic                 listed_h;
	logic                 do_ins;
	logic                 do_rm;
	logic [STAT_W-1:0]    status_nx;
	logic [CNT_W-1:0]     count_nx;

	// compare every cell against the incoming word
	always_comb begin
		logic run_i;
		logic run_r;
		run_i = 1'b0;
		run_r = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			valid[i]     = (CNT_W'(i) < count_q);
			gt[i]        = valid[i] && (slot_key_q[i] > key_s1);
			match[i]     = valid[i] && (slot_hnd_q[i] == hnd_s1);
			run_i        = run_i | (gt[i] & !tail_mode) | !valid[i];
			run_r        = run_r | match[i];
			after_ins[i] = run_i;
			after_rm[i]  = run_r;
		end
	end

	// a handle is listed exactly when one of the valid cells holds it
	assign tail_mode = (op_s1 == OP_TAIL) || (key_s1 == '1);
	assign in_range  = ({1'b0, hnd_s1} < (HND_W + 1)'(HANDLE_COUNT));
	assign listed_h  = |match;

	always_comb begin
		status_nx = STAT_OK;
		do_ins    = 1'b0;
		do_rm     = 1'b0;
		if (op_s1 == OP_NONE) begin
			status_nx = STAT_OK;
		end else if (!in_range) begin
			status_nx = STAT_ABSENT;
		end else if (op_s1 == OP_REMOVE) begin
			if (!listed_h) begin
				status_nx = STAT_ABSENT;
			end else begin
				do_rm = 1'b1;
			end
		end else if (listed_h) begin
			status_nx = STAT_LISTED;
		end else if (count_q >= CNT_W'(CAPACITY)) begin
			status_nx = STAT_FULL;
		end else begin
			do_ins = 1'b1;
		end
	end

	always_comb begin
		count_nx = count_q;
		if (do_ins) begin
			count_nx = count_q + CNT_W'(1);
		end else if (do_rm && (|match)) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1  <= opcode;
			hnd_s1 <= handle;
			key_s1 <= sort_key;
		end
		if (cmd.commit) begin
			res_count_q  <= count_nx;
			res_status_q <= status_nx;
		end
	end

	// cell chain: shift up on insert, shift down on remove
	always_ff @(posedge clk) begin
		if (cmd.commit && do_ins) begin
			if (after_ins[0]) begin
				slot_key_q[0] <= key_s1;
				slot_hnd_q[0] <= hnd_s1;
			end
			for (int i = 1; i < CAPACITY; i++) begin
				if (after_ins[i - 1]) begin
					slot_key_q[i] <= slot_key_q[i - 1];
					slot_hnd_q[i] <= slot_hnd_q[i - 1];
				end else if (after_ins[i]) begin
					slot_key_q[i] <= key_s1;
					slot_hnd_q[i] <= hnd_s1;
				end
			end
		end else if (cmd.commit && do_rm) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (after_rm[i]) begin
					slot_key_q[i] <= slot_key_q[i + 1];
					slot_hnd_q[i] <= slot_hnd_q[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nx;
		end
	end

	assign remaining_count = res_count_q;
	assign status          = res_status_q;

endmodule
`default_nettype wire

// File: rtl/sorted_tick_list_core.sv
// Bounded sorted list of up to 16 handles with 32-bit keys. A sorted insert
// goes before the first entry whose key is greater (equal keys keep arrival
// order, an all-ones key goes to the tail); insert-at-tail appends; remove
// by handle closes the gap. Each input word yields one result word with the
// entry count after the operation and a status: ok, list full, already
// listed or not listed; a rejected operation changes nothing. Each word
// is first captured and then, in the execute state, the chain of slot
// cells compares every slot against the key or handle and shifts in place.
// A new word is taken in idle while the previous result still waits on
// the output; execute only stalls while that result is still untaken.
`default_nettype none
module sorted_tick_list_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// opcode, handle, sort_key
	input  wire logic [stl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// remaining_count, status, zero padding
	output logic [stl_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
	import stl_pkg::*;

	dp_cmd_t           cmd;
	logic [CNT_W-1:0]  remaining_count;
	logic [STAT_W-1:0] status;

	stl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	stl_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.opcode          (s_axis_tdata[OP_W-1:0]),
		.handle          (s_axis_tdata[OP_W +: HND_W]),
		.sort_key        (s_axis_tdata[OP_W + HND_W +: KEY_WIDTH]),
		.remaining_count (remaining_count),
		.status          (status)
	);

	assign m_axis_tdata = OUT_DATA_W'({status, remaining_count});

endmodule
`default_nettype wire

// File: rtl/stl_checker.sv
`default_nettype none
module stl_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [stl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import stl_pkg::*;

	// a word is worked on before the next one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken on consecutive cycles");

	// a result only appears after a word has been taken
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without work");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[CNT_W-1:0] <= CNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind sorted_tick_list_core stl_checker u_stl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
